FILE: design/record_exchange_sort_top_assert.svh
// ----------------------------------------------------------------------------
// record_exchange_sort_top_assert.svh
// Assertion macros for the record exchange sort block. Each macro expects
// clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef RECORD_EXCHANGE_SORT_TOP_ASSERT_SVH
`define RECORD_EXCHANGE_SORT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/res_pkg.sv
// ----------------------------------------------------------------------------
// res_pkg
// Shared types for the record exchange sort block: input item, result item
// and the stored record layout.
// ----------------------------------------------------------------------------
package res_pkg;

	// One input transfer
	typedef struct packed {
		logic signed [15:0] key;
		logic signed [15:0] second_value;
		logic signed [15:0] third_value;
		logic signed [15:0] target_value;
		logic               sign_bit;
		logic               last;
	} in_t;

	// One result transfer
	typedef struct packed {
		logic signed [15:0] out_key;
		logic signed [15:0] out_second;
		logic signed [15:0] out_third;
		logic signed [15:0] out_target;
		logic               out_sign;
		logic               out_last;
		logic               overflow;
	} out_t;

	// Stored record: key plus 49-bit payload
	typedef struct packed {
		logic signed [15:0] key;
		logic               sign_bit;
		logic signed [15:0] target_value;
		logic signed [15:0] third_value;
		logic signed [15:0] second_value;
	} rec_t;

endpackage

FILE: design/res_cmp_unit.sv
// ----------------------------------------------------------------------------
// res_cmp_unit
// Shared compare-and-exchange unit: compares the held record against a
// candidate read from the store and picks the record to keep.
// ----------------------------------------------------------------------------
module res_cmp_unit
	import res_pkg::*;
(
	input  rec_t cur,
	input  rec_t cand,
	output logic swap,
	output rec_t keep
);

	// Swap on a strictly smaller candidate key; equal keys stay put
	assign swap = ($signed(cur.key) > $signed(cand.key));
	assign keep = swap ? cand : cur;

endmodule

FILE: design/record_exchange_sort_top.sv
// ----------------------------------------------------------------------------
// record_exchange_sort_top
// Loads records into a store, sorts them by signed key in exchange-sort
// order with one shared compare unit, then streams them out in order.
//
//   channel | signals                          | payload
//   --------+----------------------------------+---------------------------
//   input   | item_valid, item_ready, item     | key, three values, sign, last
//   output  | result_valid, result_ready, result | sorted record, last, overflow
//
// Load: one cycle per input item; item_ready is high only while loading.
// Sort (n stored records, n >= 2): runs through the single read port of the
// record store and the shared compare unit.
// Emit: a setup read, then each result is loaded and held until result_ready is high.
// A stalled result holds in the output register; no input is taken until the
// last result of a set transfers. Reset clears the count and overflow state;
// the store itself is not cleared.
// ----------------------------------------------------------------------------
module record_exchange_sort_top
	import res_pkg::*;
#(
	parameter int MAX_RECORDS = 32
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  in_t  item,
	output logic result_valid,
	input  logic result_ready,
	output out_t result
);

	localparam int AW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	typedef enum logic [7:0] {
		ST_LOAD = 8'b0000_0001,
		ST_RDI  = 8'b0000_0010,
		ST_LDI  = 8'b0000_0100,
		ST_SCAN = 8'b0000_1000,
		ST_WB   = 8'b0001_0000,
		ST_EMRD = 8'b0010_0000,
		ST_EMLD = 8'b0100_0000,
		ST_EMWT = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic               drop_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   k_q;
	logic               pend_q;
	logic               result_valid_q;
	logic [AW-1:0]      jd_q;
	rec_t               cur_q;
	rec_t               rd_data_q;
	out_t               result_q;

	rec_t               rec_mem [MAX_RECORDS];
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	rec_t               mem_wdata;
	logic [AW-1:0]      mem_raddr;

	logic               full;
	logic [CNT_W-1:0]   n_new;
	logic [CNT_W-1:0]   k_next;
	logic               swap;
	rec_t               keep;
	rec_t               item_rec;

	// Handshake and status
	assign item_ready   = (state_q == ST_LOAD);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign full   = (count_q == CNT_W'(MAX_RECORDS));
	assign n_new  = full ? count_q : (count_q + CNT_W'(1));
	assign k_next = k_q + CNT_W'(1);

	// Pack the incoming item as a stored record
	assign item_rec = '{
		key:          item.key,
		sign_bit:     item.sign_bit,
		target_value: item.target_value,
		third_value:  item.third_value,
		second_value: item.second_value
	};

	// Shared compare unit
	res_cmp_unit u_cmp (
		.cur  (cur_q),
		.cand (rd_data_q),
		.swap (swap),
		.keep (keep)
	);

	// Select store write and read ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = item_rec;
		mem_raddr = '0;
		case (state_q)
			ST_LOAD: begin
				mem_we = item_valid && !full;
			end
			ST_RDI: begin
				mem_raddr = i_q[AW-1:0];
			end
			ST_SCAN: begin
				mem_raddr = j_q[AW-1:0];
				mem_we    = pend_q && swap;
				mem_waddr = jd_q;
				mem_wdata = cur_q;
			end
			ST_WB: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[AW-1:0];
				mem_wdata = cur_q;
			end
			ST_EMRD: begin
				mem_raddr = k_q[AW-1:0];
			end
			ST_EMWT: begin
				mem_raddr = k_next[AW-1:0];
			end
			default: begin
				mem_raddr = '0;
			end
		endcase
	end

	// Record store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rec_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= rec_mem[mem_raddr];
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			count_q        <= '0;
			drop_q         <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			pend_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (item_valid) begin
						count_q <= n_new;
						if (full) begin
							drop_q <= 1'b1;
						end
						if (item.last) begin
							i_q     <= '0;
							k_q     <= '0;
							state_q <= (n_new >= CNT_W'(2)) ? ST_RDI : ST_EMRD;
						end
					end
				end
				ST_RDI: begin
					state_q <= ST_LDI;
				end
				ST_LDI: begin
					j_q     <= i_q + CNT_W'(1);
					pend_q  <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q != count_q) begin
						j_q    <= j_q + CNT_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_WB;
						end
					end
				end
				ST_WB: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= ((i_q + CNT_W'(2)) < count_q) ? ST_RDI : ST_EMRD;
				end
				ST_EMRD: begin
					state_q <= ST_EMLD;
				end
				ST_EMLD: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_EMWT;
				end
				ST_EMWT: begin
					if (result_ready) begin
						result_valid_q <= 1'b0;
						if (result_q.out_last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_next;
							state_q <= ST_EMLD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Held record, scan index and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_LDI) begin
			cur_q <= rd_data_q;
		end
		if (state_q == ST_SCAN) begin
			if (j_q != count_q) begin
				jd_q <= j_q[AW-1:0];
			end
			if (pend_q) begin
				cur_q <= keep;
			end
		end
		if (state_q == ST_EMLD) begin
			result_q.out_key    <= rd_data_q.key;
			result_q.out_second <= rd_data_q.second_value;
			result_q.out_third  <= rd_data_q.third_value;
			result_q.out_target <= rd_data_q.target_value;
			result_q.out_sign   <= rd_data_q.sign_bit;
			result_q.out_last   <= (k_next == count_q);
			result_q.overflow   <= drop_q;
		end
	end

endmodule

FILE: design/res_checker.sv
// ----------------------------------------------------------------------------
// res_checker
// Port-level checks for the record exchange sort block, bound to the top.
// ----------------------------------------------------------------------------
`include "record_exchange_sort_top_assert.svh"

module res_checker
	import res_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input in_t  item,
	input logic result_valid,
	input logic result_ready,
	input out_t result
);

	// Hold a stalled result
	`RES_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

	// Never load while results are pending
	`RES_ASSERT_SAME(a_no_overlap, 1'b1, !(item_ready && result_valid), "input ready during emission")

	// Stop taking input after the last record of a set
	`RES_ASSERT_NEXT(a_last_stops_load, item_valid && item_ready && item.last, !item_ready, "input still ready after last")

	// End the set after the final result transfers
	`RES_ASSERT_NEXT(a_set_ends, result_valid && result_ready && result.out_last, !result_valid && item_ready, "emission continued past final result")

endmodule

bind record_exchange_sort_top res_checker u_res_checker (.*);
